// ----- rtl/dso_pkg.sv -----
// ---------------------------------------------------------------------------
// dso_pkg
// shared sizes, command and status codes, structs and modular pointer math
// for the dual stack operation engine
// ---------------------------------------------------------------------------
package dso_pkg;

    localparam int DEPTH   = 512;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = ADDR_W + 1;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 4;
    localparam int REP_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 10;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [REP_W-1:0]   rep_t;
    typedef logic [STAT_W-1:0]  stat_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam cmd_t CMD_LOAD  = 4'd0;
    localparam cmd_t CMD_CLEAR = 4'd1;
    localparam cmd_t CMD_SA    = 4'd2;
    localparam cmd_t CMD_SB    = 4'd3;
    localparam cmd_t CMD_SS    = 4'd4;
    localparam cmd_t CMD_PA    = 4'd5;
    localparam cmd_t CMD_PB    = 4'd6;
    localparam cmd_t CMD_RA    = 4'd7;
    localparam cmd_t CMD_RB    = 4'd8;
    localparam cmd_t CMD_RR    = 4'd9;
    localparam cmd_t CMD_RRA   = 4'd10;
    localparam cmd_t CMD_RRB   = 4'd11;
    localparam cmd_t CMD_RRR   = 4'd12;

    localparam stat_t ST_DONE = 2'd0;
    localparam stat_t ST_SKIP = 2'd1;
    localparam stat_t ST_FULL = 2'd2;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        addr_t raddr;
    } ram_req_t;

    typedef struct packed {
        rep_t   moves_done;
        count_t count_b;
        count_t count_a;
        data_t  top_b;
        data_t  top_a;
        stat_t  status;
    } result_t;

    // a below DEPTH, b up to DEPTH
    function automatic addr_t add_mod(input addr_t a, input fill_t b);
        fill_t s;
        s = fill_t'(a) + b;
        if (s >= fill_t'(DEPTH))
        begin
            s = s - fill_t'(DEPTH);
        end
        return addr_t'(s);
    endfunction

    function automatic addr_t inc_mod(input addr_t a);
        addr_t r;
        if (a == addr_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + addr_t'(1);
        end
        return r;
    endfunction

    function automatic addr_t dec_mod(input addr_t a);
        addr_t r;
        if (a == '0)
        begin
            r = addr_t'(DEPTH - 1);
        end
        else
        begin
            r = a - addr_t'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/dso_ram.sv -----
// ---------------------------------------------------------------------------
// dso_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module dso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/dso_seq.sv -----
// ---------------------------------------------------------------------------
// dso_seq
// command sequencer: pointer and fill registers, per repetition read and
// write steps on both stack memories, result capture
// ---------------------------------------------------------------------------
module dso_seq
    import dso_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cmd_t     cmd,
    input  rep_t     repeat_req,
    input  data_t    value,
    output ram_req_t req_a,
    output ram_req_t req_b,
    input  data_t    rdata_a,
    input  data_t    rdata_b,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_SW_RD1,
        S_SW_RD2,
        S_SW_WR1,
        S_SW_WR2,
        S_TOP_RD,
        S_TOP_CAP,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    addr_t   head_a_reg, head_a_next;
    addr_t   head_b_reg, head_b_next;
    fill_t   fill_a_reg, fill_a_next;
    fill_t   fill_b_reg, fill_b_next;
    cmd_t    cmd_reg, cmd_next;
    rep_t    rem_reg, rem_next;
    rep_t    moves_reg, moves_next;
    stat_t   status_reg, status_next;
    logic    en_a_reg, en_a_next;
    logic    en_b_reg, en_b_next;
    data_t   tmp_a_reg, tmp_a_next;
    data_t   tmp_b_reg, tmp_b_next;
    result_t res_reg, res_next;

    logic a_nz, b_nz, a_ge2, b_ge2, a_full, b_full;
    logic is_push, rot_up;

    assign a_nz   = (fill_a_reg != '0);
    assign b_nz   = (fill_b_reg != '0);
    assign a_ge2  = (fill_a_reg >= fill_t'(2));
    assign b_ge2  = (fill_b_reg >= fill_t'(2));
    assign a_full = (fill_a_reg == fill_t'(DEPTH));
    assign b_full = (fill_b_reg == fill_t'(DEPTH));

    assign is_push = (cmd_reg == CMD_PA) || (cmd_reg == CMD_PB);
    assign rot_up  = (cmd_reg == CMD_RA) || (cmd_reg == CMD_RB) || (cmd_reg == CMD_RR);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        head_a_next = head_a_reg;
        head_b_next = head_b_reg;
        fill_a_next = fill_a_reg;
        fill_b_next = fill_b_reg;
        cmd_next    = cmd_reg;
        rem_next    = rem_reg;
        moves_next  = moves_reg;
        status_next = status_reg;
        en_a_next   = en_a_reg;
        en_b_next   = en_b_reg;
        tmp_a_next  = tmp_a_reg;
        tmp_b_next  = tmp_b_reg;
        res_next    = res_reg;

        req_a.we    = 1'b0;
        req_a.waddr = head_a_reg;
        req_a.wdata = rdata_a;
        req_a.raddr = head_a_reg;
        req_b.we    = 1'b0;
        req_b.waddr = head_b_reg;
        req_b.wdata = rdata_b;
        req_b.raddr = head_b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    rem_next    = repeat_req;
                    moves_next  = '0;
                    status_next = ST_DONE;
                    en_a_next   = 1'b0;
                    en_b_next   = 1'b0;
                    state_next  = S_TOP_RD;
                    unique case (cmd) inside
                        CMD_LOAD:
                        begin
                            if (a_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                req_a.we    = 1'b1;
                                req_a.waddr = add_mod(head_a_reg, fill_a_reg);
                                req_a.wdata = value;
                                fill_a_next = fill_a_reg + fill_t'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_a_next = '0;
                            head_b_next = '0;
                            fill_a_next = '0;
                            fill_b_next = '0;
                        end
                        CMD_SA:
                        begin
                            if (!a_ge2)
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                moves_next = repeat_req;
                                en_a_next  = 1'b1;
                                if (repeat_req[0])
                                begin
                                    state_next = S_SW_RD1;
                                end
                            end
                        end
                        CMD_SB:
                        begin
                            if (!b_ge2)
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                moves_next = repeat_req;
                                en_b_next  = 1'b1;
                                if (repeat_req[0])
                                begin
                                    state_next = S_SW_RD1;
                                end
                            end
                        end
                        CMD_SS:
                        begin
                            if (!(a_nz && b_nz))
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                moves_next = repeat_req;
                                en_a_next  = a_ge2;
                                en_b_next  = b_ge2;
                                if (repeat_req[0] && (a_ge2 || b_ge2))
                                begin
                                    state_next = S_SW_RD1;
                                end
                            end
                        end
                        CMD_PA:
                        begin
                            if (!b_nz)
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        CMD_PB:
                        begin
                            if (!a_nz)
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        CMD_RA, CMD_RRA:
                        begin
                            if (!a_nz)
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                moves_next = repeat_req;
                                en_a_next  = a_ge2;
                                if (a_ge2)
                                begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        CMD_RB, CMD_RRB:
                        begin
                            if (!b_nz)
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                moves_next = repeat_req;
                                en_b_next  = b_ge2;
                                if (b_ge2)
                                begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        CMD_RR, CMD_RRR:
                        begin
                            if (!(a_nz && b_nz))
                            begin
                                status_next = ST_SKIP;
                            end
                            else
                            begin
                                moves_next = repeat_req;
                                en_a_next  = a_ge2;
                                en_b_next  = b_ge2;
                                if (a_ge2 || b_ge2)
                                begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_SKIP;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (is_push)
                begin
                    if ((rem_reg == '0) ||
                        ((cmd_reg == CMD_PA) && (!b_nz || a_full)) ||
                        ((cmd_reg == CMD_PB) && (!a_nz || b_full)))
                    begin
                        state_next = S_TOP_RD;
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
                else
                begin
                    // reverse rotation fetches the bottom element
                    if (!rot_up)
                    begin
                        req_a.raddr = add_mod(head_a_reg, fill_a_reg - fill_t'(1));
                        req_b.raddr = add_mod(head_b_reg, fill_b_reg - fill_t'(1));
                    end
                    if (rem_reg == '0)
                    begin
                        state_next = S_TOP_RD;
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
            end
            S_WR:
            begin
                rem_next   = rem_reg - rep_t'(1);
                state_next = S_RD;
                if (cmd_reg == CMD_PB)
                begin
                    req_b.we    = 1'b1;
                    req_b.waddr = dec_mod(head_b_reg);
                    req_b.wdata = rdata_a;
                    head_b_next = dec_mod(head_b_reg);
                    fill_b_next = fill_b_reg + fill_t'(1);
                    head_a_next = inc_mod(head_a_reg);
                    fill_a_next = fill_a_reg - fill_t'(1);
                    moves_next  = moves_reg + rep_t'(1);
                end
                else if (cmd_reg == CMD_PA)
                begin
                    req_a.we    = 1'b1;
                    req_a.waddr = dec_mod(head_a_reg);
                    req_a.wdata = rdata_b;
                    head_a_next = dec_mod(head_a_reg);
                    fill_a_next = fill_a_reg + fill_t'(1);
                    head_b_next = inc_mod(head_b_reg);
                    fill_b_next = fill_b_reg - fill_t'(1);
                    moves_next  = moves_reg + rep_t'(1);
                end
                else
                begin
                    if (en_a_reg)
                    begin
                        req_a.we = 1'b1;
                        if (rot_up)
                        begin
                            req_a.waddr = add_mod(head_a_reg, fill_a_reg);
                            head_a_next = inc_mod(head_a_reg);
                        end
                        else
                        begin
                            req_a.waddr = dec_mod(head_a_reg);
                            head_a_next = dec_mod(head_a_reg);
                        end
                    end
                    if (en_b_reg)
                    begin
                        req_b.we = 1'b1;
                        if (rot_up)
                        begin
                            req_b.waddr = add_mod(head_b_reg, fill_b_reg);
                            head_b_next = inc_mod(head_b_reg);
                        end
                        else
                        begin
                            req_b.waddr = dec_mod(head_b_reg);
                            head_b_next = dec_mod(head_b_reg);
                        end
                    end
                end
            end
            S_SW_RD1:
            begin
                state_next = S_SW_RD2;
            end
            S_SW_RD2:
            begin
                req_a.raddr = inc_mod(head_a_reg);
                req_b.raddr = inc_mod(head_b_reg);
                tmp_a_next  = rdata_a;
                tmp_b_next  = rdata_b;
                state_next  = S_SW_WR1;
            end
            S_SW_WR1:
            begin
                req_a.we   = en_a_reg;
                req_b.we   = en_b_reg;
                state_next = S_SW_WR2;
            end
            S_SW_WR2:
            begin
                req_a.we    = en_a_reg;
                req_a.waddr = inc_mod(head_a_reg);
                req_a.wdata = tmp_a_reg;
                req_b.we    = en_b_reg;
                req_b.waddr = inc_mod(head_b_reg);
                req_b.wdata = tmp_b_reg;
                state_next  = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                state_next = S_TOP_CAP;
            end
            S_TOP_CAP:
            begin
                res_next.status     = status_reg;
                res_next.top_a      = a_nz ? rdata_a : '0;
                res_next.top_b      = b_nz ? rdata_b : '0;
                res_next.count_a    = count_t'(fill_a_reg);
                res_next.count_b    = count_t'(fill_b_reg);
                res_next.moves_done = moves_reg;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_a_reg <= '0;
            head_b_reg <= '0;
            fill_a_reg <= '0;
            fill_b_reg <= '0;
            cmd_reg    <= CMD_LOAD;
            rem_reg    <= '0;
            moves_reg  <= '0;
            status_reg <= ST_DONE;
            en_a_reg   <= 1'b0;
            en_b_reg   <= 1'b0;
            tmp_a_reg  <= '0;
            tmp_b_reg  <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_a_reg <= head_a_next;
            head_b_reg <= head_b_next;
            fill_a_reg <= fill_a_next;
            fill_b_reg <= fill_b_next;
            cmd_reg    <= cmd_next;
            rem_reg    <= rem_next;
            moves_reg  <= moves_next;
            status_reg <= status_next;
            en_a_reg   <= en_a_next;
            en_b_reg   <= en_b_next;
            tmp_a_reg  <= tmp_a_next;
            tmp_b_reg  <= tmp_b_next;
            res_reg    <= res_next;
        end
    end

endmodule

// ----- rtl/dual_stack_op_engine.sv -----
// ---------------------------------------------------------------------------
// dual_stack_op_engine
// two circular buffer stacks with swap, push, rotate and load commands
//
// s_axis carries one command beat: tuser holds the command code, tdata the
// repeat count and the load value. m_axis returns one result beat per
// command: status, both tops, both counts and the repetitions carried out.
// s_axis_tready is high only while the sequencer is idle; one command is
// worked at a time. Load, clear, skipped commands and moves that change
// nothing go straight to the top read; a swap is carried out only when the
// repeat count is odd; rotations on two or more elements repeat for each
// count, pushes for each push made. s_axis_tready rises with m_axis_tvalid.
// Each repetition is one registered memory read followed by one write on
// the two stack rams.
// The result moves to an output register and the sequencer goes idle; a
// stalled m_axis holds the beat, and the next command then waits finished
// in the sequencer with s_axis_tready low. Reset empties both stacks at
// once; ram contents are not cleared and an empty stack reports a zero top.
// ---------------------------------------------------------------------------
module dual_stack_op_engine
    import dso_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // repeat_req[7:0], value[39:8]
    input  logic [3:0]  s_axis_tuser,   // cmd[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // status[1:0], top_a[33:2], top_b[65:34],
                                        // count_a[75:66], count_b[85:76],
                                        // moves_done[93:86], zero[95:94]
);

    ram_req_t req_a, req_b;
    data_t    rdata_a, rdata_b;
    logic     res_valid, res_ready;
    result_t  res;

    logic     out_valid_reg;
    result_t  out_data_reg;

    dso_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram_a (
        .clk  (clk),
        .we   (req_a.we),
        .waddr(req_a.waddr),
        .wdata(req_a.wdata),
        .raddr(req_a.raddr),
        .rdata(rdata_a)
    );

    dso_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram_b (
        .clk  (clk),
        .we   (req_b.we),
        .waddr(req_b.waddr),
        .wdata(req_b.wdata),
        .raddr(req_b.raddr),
        .rdata(rdata_b)
    );

    dso_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (s_axis_tuser),
        .repeat_req(s_axis_tdata[7:0]),
        .value     (s_axis_tdata[39:8]),
        .req_a     (req_a),
        .req_b     (req_b),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule
